FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clock
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define UVS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define UVS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// types, constants and helpers of the uv sphere point generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

   localparam int MAX_DIVISIONS       = 1024;
   localparam int COORD_BITS_DEFAULT  = 16;
   localparam int IDX_BITS            = 11;
   localparam int TEX_BITS            = 17;
   localparam int VTX_BITS            = 21;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int DIV_STEPS           = 33;
   localparam int DIV_NUM_BITS        = IDX_BITS + DIV_STEPS;
   localparam int CORDIC_ITERS        = 28;
   localparam int CORDIC_BITS         = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STACK_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECTOR_COUNT = 2'd1;

   localparam logic [IDX_BITS-1:0] STACK_COUNT_RESET  = 11'd18;
   localparam logic [IDX_BITS-1:0] SECTOR_COUNT_RESET = 11'd36;
   localparam logic [IDX_BITS-1:0] STACK_COUNT_MIN    = 11'd2;
   localparam logic [IDX_BITS-1:0] SECTOR_COUNT_MIN   = 11'd3;

   localparam logic signed [CORDIC_BITS-1:0] CORDIC_X0  = 32'sd652032874;
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_ONE = 32'sd1073741824;

   // divider lanes
   localparam int LANE_TEX_V  = 0;
   localparam int LANE_THETA  = 1;
   localparam int LANE_TEX_U  = 2;
   localparam int LANE_PHI    = 3;
   localparam int DIV_LANES   = 4;

   typedef struct packed {
      logic [IDX_BITS-1:0]  rem;
      logic [DIV_STEPS-1:0] num;
      logic [DIV_STEPS-1:0] quo;
   } div_type;

   typedef struct packed {
      logic                          hold;
      logic [1:0]                    quad;
      logic signed [CORDIC_BITS-1:0] x;
      logic signed [CORDIC_BITS-1:0] y;
      logic signed [CORDIC_BITS-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic                point_valid;
      logic                upper_tri;
      logic                lower_tri;
      logic [VTX_BITS-1:0] top_index;
      logic [VTX_BITS-1:0] bottom_index;
      logic [TEX_BITS-1:0] tex_u;
      logic [TEX_BITS-1:0] tex_v;
   } side_type;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic signed [CORDIC_BITS-1:0] cordic_atan(input int i);
      logic signed [CORDIC_BITS-1:0] a;
      case (i)
         0:       a = 32'sd536870912;
         1:       a = 32'sd316933406;
         2:       a = 32'sd167458907;
         3:       a = 32'sd85004756;
         4:       a = 32'sd42667331;
         5:       a = 32'sd21354465;
         6:       a = 32'sd10679838;
         7:       a = 32'sd5340245;
         8:       a = 32'sd2670163;
         9:       a = 32'sd1335087;
         10:      a = 32'sd667544;
         11:      a = 32'sd333772;
         12:      a = 32'sd166885;
         13:      a = 32'sd83443;
         14:      a = 32'sd41721;
         15:      a = 32'sd20861;
         16:      a = 32'sd10430;
         17:      a = 32'sd5215;
         18:      a = 32'sd2608;
         19:      a = 32'sd1304;
         20:      a = 32'sd652;
         21:      a = 32'sd326;
         22:      a = 32'sd163;
         23:      a = 32'sd81;
         24:      a = 32'sd41;
         25:      a = 32'sd20;
         26:      a = 32'sd10;
         27:      a = 32'sd5;
         default: a = '0;
      endcase
      return a;
   endfunction

   // floor(((numer << shift) + floor(denom / 2)) / denom), start of long division
   function automatic div_type div_seed(input logic [IDX_BITS-1:0] numer,
                                        input logic [IDX_BITS-1:0] denom,
                                        input int unsigned shift);
      logic [DIV_NUM_BITS-1:0] full;
      div_type                 d;
      full  = ({{DIV_STEPS{1'b0}}, numer} << shift) | {{(DIV_STEPS+1){1'b0}}, denom[IDX_BITS-1:1]};
      d.rem = full[DIV_NUM_BITS-1:DIV_STEPS];
      d.num = full[DIV_STEPS-1:0];
      d.quo = '0;
      return d;
   endfunction

   // quadrant split of a phase, axis angles bypass the rotation
   function automatic cordic_type cordic_seed(input logic [CORDIC_BITS-1:0] phase);
      cordic_type c;
      c.quad = phase[31:30];
      c.hold = (phase[29:0] == 30'd0);
      c.x    = c.hold ? CORDIC_ONE : CORDIC_X0;
      c.y    = '0;
      c.z    = {2'b00, phase[29:0]};
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/uv_sphere_vertex_and_index_gen_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_index_gen_core
// grid point to position, texture coordinates, vertex indices and flags
//
// usage:
// - req channel carries one grid point (ring, sector) per request,
//   taken when req_valid is high and req_stall is low
// - rsp channel returns one result per request, in order, taken when
//   rsp_valid is high and rsp_stall is low
// - csr channel writes stack_count (index 0) or sector_count (index 1),
//   always ready; write only while no request is in flight
// - the pipeline holds 33 divider cells, 28 cordic cells, quadrant
//   fix, product and rounding stages; one request per cycle sustained while no result is stalled
// - a stalled result freezes the whole pipeline and raises req_stall in
//   the same cycle
// - reset empties the pipeline and loads counts 18 and 36
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uv_sphere_vertex_and_index_gen_core #(
   parameter int COORD_BITS = uvs_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [uvs_pkg::IDX_BITS-1:0]         req_ring,
   input  wire  [uvs_pkg::IDX_BITS-1:0]         req_sector,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_point_valid,
   output logic signed [COORD_BITS-1:0]         rsp_pos_x,
   output logic signed [COORD_BITS-1:0]         rsp_pos_y,
   output logic signed [COORD_BITS-1:0]         rsp_pos_z,
   output logic [uvs_pkg::TEX_BITS-1:0]         rsp_tex_u,
   output logic [uvs_pkg::TEX_BITS-1:0]         rsp_tex_v,
   output logic                                 rsp_upper_tri,
   output logic                                 rsp_lower_tri,
   output logic [uvs_pkg::VTX_BITS-1:0]         rsp_top_index,
   output logic [uvs_pkg::VTX_BITS-1:0]         rsp_bottom_index,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [uvs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [uvs_pkg::IDX_BITS-1:0]         csr_data
);
   import uvs_pkg::*;

   localparam int TEX_STAGE  = DIV_STEPS;
   localparam int TRIG_STAGE = DIV_STEPS + CORDIC_ITERS;
   localparam int LAST       = TRIG_STAGE + 2;
   localparam int SHIFT      = 61 - COORD_BITS;
   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (SHIFT - 1);
   localparam logic signed [63:0] COORD_MAX  = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] COORD_MIN  = -(64'sd1 <<< (COORD_BITS - 1));

   typedef struct packed {
      logic signed [CORDIC_BITS-1:0] ct;
      logic signed [CORDIC_BITS-1:0] st;
      logic signed [CORDIC_BITS-1:0] cp;
      logic signed [CORDIC_BITS-1:0] sp;
   } trig_type;

   logic [IDX_BITS-1:0]  stack_count_ff;
   logic [IDX_BITS-1:0]  sector_count_ff;
   logic [IDX_BITS-1:0]  stacks;
   logic [IDX_BITS-1:0]  sectors;
   logic [IDX_BITS:0]    sectors_p1;
   logic                 advance;
   logic [LAST:0]        vld_ff;

   div_type              div_link [DIV_LANES][DIV_STEPS+1];
   logic [IDX_BITS-1:0]  lane_div [DIV_LANES];
   cordic_type           cor_link [2][CORDIC_ITERS+1];

   side_type             side_ff [LAST];
   side_type             side_in [LAST];
   logic [22:0]          k1_full;
   logic [23:0]          k2_full;

   trig_type             trig_ff;
   trig_type             trig_in;
   logic signed [63:0]   prod_x_ff;
   logic signed [63:0]   prod_y_ff;
   logic signed [63:0]   prod_z_ff;
   logic signed [63:0]   prod_x_in;
   logic signed [63:0]   prod_y_in;
   logic signed [63:0]   prod_z_in;

   side_type                    out_side_ff;
   side_type                    out_side_in;
   logic signed [COORD_BITS-1:0] pos_x_ff;
   logic signed [COORD_BITS-1:0] pos_y_ff;
   logic signed [COORD_BITS-1:0] pos_z_ff;
   logic signed [COORD_BITS-1:0] pos_x_in;
   logic signed [COORD_BITS-1:0] pos_y_in;
   logic signed [COORD_BITS-1:0] pos_z_in;

   function automatic logic [IDX_BITS-1:0] clamp_count(input logic [IDX_BITS-1:0] v,
                                                       input logic [IDX_BITS-1:0] lo);
      logic [IDX_BITS-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (int'(v) > MAX_DIVISIONS) begin
         r = IDX_BITS'(MAX_DIVISIONS);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] to_coord(input logic signed [63:0] v);
      logic signed [63:0] r;
      logic signed [63:0] s;
      r = (v + ROUND_HALF) >>> SHIFT;
      if (r > COORD_MAX) begin
         s = COORD_MAX;
      end else if (r < COORD_MIN) begin
         s = COORD_MIN;
      end else begin
         s = r;
      end
      return s[COORD_BITS-1:0];
   endfunction

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff  <= STACK_COUNT_RESET;
         sector_count_ff <= SECTOR_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STACK_COUNT:  stack_count_ff  <= csr_data;
            CSR_SECTOR_COUNT: sector_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign stacks     = clamp_count(stack_count_ff, STACK_COUNT_MIN);
   assign sectors    = clamp_count(sector_count_ff, SECTOR_COUNT_MIN);
   assign sectors_p1 = {1'b0, sectors} + 12'd1;

   // pipeline control
   assign advance   = !(vld_ff[LAST] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   // divider chains
   always_comb begin
      lane_div[LANE_TEX_V]    = stacks;
      lane_div[LANE_THETA]    = stacks;
      lane_div[LANE_TEX_U]    = sectors;
      lane_div[LANE_PHI]      = sectors;
   end

   assign div_link[LANE_TEX_V][0] = div_seed(req_ring, stacks, 16);
   assign div_link[LANE_THETA][0] = div_seed(req_ring, stacks, 31);
   assign div_link[LANE_TEX_U][0] = div_seed(req_sector, sectors, 16);
   assign div_link[LANE_PHI][0]   = div_seed(req_sector, sectors, 32);

   for (genvar l = 0; l < DIV_LANES; l++) begin : g_div_lane
      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div_cell
         uvs_div_cell u_cell (
            .clock     (clock),
            .advance   (advance),
            .divisor   (lane_div[l]),
            .from_prev (div_link[l][j]),
            .to_next   (div_link[l][j+1])
         );
      end
   end

   // cordic chains, theta then phi
   assign cor_link[0][0] = cordic_seed(div_link[LANE_THETA][DIV_STEPS].quo[CORDIC_BITS-1:0]);
   assign cor_link[1][0] = cordic_seed(div_link[LANE_PHI][DIV_STEPS].quo[CORDIC_BITS-1:0]);

   for (genvar a = 0; a < 2; a++) begin : g_cor_lane
      for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cor_cell
         uvs_cordic_cell #(
            .ITER (i)
         ) u_cell (
            .clock     (clock),
            .advance   (advance),
            .from_prev (cor_link[a][i]),
            .to_next   (cor_link[a][i+1])
         );
      end
   end

   // side data carried beside the chains
   always_comb begin
      k1_full = 23'(req_ring) * 23'(sectors_p1) + 23'(req_sector);
      k2_full = 24'(k1_full) + 24'(sectors_p1);
      side_in[0].point_valid  = (req_ring <= stacks) && (req_sector <= sectors);
      side_in[0].upper_tri    = 1'b0;
      side_in[0].lower_tri    = 1'b0;
      if ((req_ring < stacks) && (req_sector < sectors)) begin
         side_in[0].upper_tri = (req_ring != '0);
         side_in[0].lower_tri = (req_ring != (stacks - 11'd1));
      end
      side_in[0].top_index    = k1_full[VTX_BITS-1:0];
      side_in[0].bottom_index = k2_full[VTX_BITS-1:0];
      side_in[0].tex_u        = '0;
      side_in[0].tex_v        = '0;
      for (int s = 1; s < LAST; s++) begin
         side_in[s] = side_ff[s-1];
      end
      side_in[TEX_STAGE].tex_u = div_link[LANE_TEX_U][DIV_STEPS].quo[TEX_BITS-1:0];
      side_in[TEX_STAGE].tex_v = div_link[LANE_TEX_V][DIV_STEPS].quo[TEX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < LAST; s++) begin
            side_ff[s] <= side_in[s];
         end
      end
   end

   // quadrant fix
   always_comb begin
      case (cor_link[0][CORDIC_ITERS].quad)
         2'd0: begin
            trig_in.ct = cor_link[0][CORDIC_ITERS].x;
            trig_in.st = cor_link[0][CORDIC_ITERS].y;
         end
         2'd1: begin
            trig_in.ct = -cor_link[0][CORDIC_ITERS].y;
            trig_in.st = cor_link[0][CORDIC_ITERS].x;
         end
         2'd2: begin
            trig_in.ct = -cor_link[0][CORDIC_ITERS].x;
            trig_in.st = -cor_link[0][CORDIC_ITERS].y;
         end
         default: begin
            trig_in.ct = cor_link[0][CORDIC_ITERS].y;
            trig_in.st = -cor_link[0][CORDIC_ITERS].x;
         end
      endcase
      case (cor_link[1][CORDIC_ITERS].quad)
         2'd0: begin
            trig_in.cp = cor_link[1][CORDIC_ITERS].x;
            trig_in.sp = cor_link[1][CORDIC_ITERS].y;
         end
         2'd1: begin
            trig_in.cp = -cor_link[1][CORDIC_ITERS].y;
            trig_in.sp = cor_link[1][CORDIC_ITERS].x;
         end
         2'd2: begin
            trig_in.cp = -cor_link[1][CORDIC_ITERS].x;
            trig_in.sp = -cor_link[1][CORDIC_ITERS].y;
         end
         default: begin
            trig_in.cp = cor_link[1][CORDIC_ITERS].y;
            trig_in.sp = -cor_link[1][CORDIC_ITERS].x;
         end
      endcase
   end

   // products, z brought to the same scale
   always_comb begin
      prod_x_in = 64'(trig_ff.st) * 64'(trig_ff.cp);
      prod_y_in = 64'(trig_ff.st) * 64'(trig_ff.sp);
      prod_z_in = 64'(trig_ff.ct) <<< 30;
   end

   // rounding, saturation and masking of invalid points
   always_comb begin
      out_side_in = side_ff[LAST-1];
      pos_x_in    = to_coord(prod_x_ff);
      pos_y_in    = to_coord(prod_y_ff);
      pos_z_in    = to_coord(prod_z_ff);
      if (!side_ff[LAST-1].point_valid) begin
         out_side_in = '0;
         pos_x_in    = '0;
         pos_y_in    = '0;
         pos_z_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trig_ff     <= trig_in;
         prod_x_ff   <= prod_x_in;
         prod_y_ff   <= prod_y_in;
         prod_z_ff   <= prod_z_in;
         out_side_ff <= out_side_in;
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         pos_z_ff    <= pos_z_in;
      end
   end

   assign rsp_valid        = vld_ff[LAST];
   assign rsp_point_valid  = out_side_ff.point_valid;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_tex_u        = out_side_ff.tex_u;
   assign rsp_tex_v        = out_side_ff.tex_v;
   assign rsp_upper_tri    = out_side_ff.upper_tri;
   assign rsp_lower_tri    = out_side_ff.lower_tri;
   assign rsp_top_index    = out_side_ff.top_index;
   assign rsp_bottom_index = out_side_ff.bottom_index;

   `include "assert_macros.svh"

   `UVS_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "response valid right after reset")
   `UVS_ASSERT(a_invalid_zero,
      rsp_valid && !rsp_point_valid |-> rsp_pos_x == '0 && rsp_pos_y == '0 &&
      rsp_pos_z == '0 && rsp_tex_u == '0 && rsp_tex_v == '0 && rsp_top_index == '0 &&
      rsp_bottom_index == '0 && !rsp_upper_tri && !rsp_lower_tri,
      "invalid point with nonzero fields")
   `UVS_ASSERT(a_index_step,
      rsp_valid && rsp_point_valid |->
      rsp_bottom_index == VTX_BITS'(rsp_top_index + VTX_BITS'(sectors_p1)),
      "bottom index not one row below top index")
   `UVS_ASSERT(a_upper_ring, rsp_valid && rsp_upper_tri |-> rsp_point_valid && rsp_tex_v != '0, "upper triangle on the first ring")
   `UVS_ASSERT(a_tri_sector, rsp_valid && (rsp_upper_tri || rsp_lower_tri) |-> rsp_tex_u != 17'h10000, "triangle flagged on the seam column")

endmodule

`default_nettype wire

FILE: design/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell
// one restoring division step, one quotient bit per cycle while advance is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uvs_div_cell (
   input  wire                                clock,
   input  wire                                advance,
   input  wire  [uvs_pkg::IDX_BITS-1:0]       divisor,
   input  wire  uvs_pkg::div_type             from_prev,
   output uvs_pkg::div_type                   to_next
);
   import uvs_pkg::*;

   div_type             div_ff;
   div_type             div_in;
   logic [IDX_BITS:0]   trial;
   logic [IDX_BITS:0]   diff;
   logic                fits;

   always_comb begin
      trial      = {from_prev.rem, from_prev.num[DIV_STEPS-1]};
      fits       = (trial >= {1'b0, divisor});
      diff       = trial - {1'b0, divisor};
      div_in.rem = fits ? diff[IDX_BITS-1:0] : trial[IDX_BITS-1:0];
      div_in.num = {from_prev.num[DIV_STEPS-2:0], 1'b0};
      div_in.quo = {from_prev.quo[DIV_STEPS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff <= div_in;
      end
   end

   assign to_next = div_ff;

endmodule

`default_nettype wire

FILE: design/uvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// one rotation-mode cordic iteration with a fixed shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uvs_cordic_cell #(
   parameter int ITER = 0
) (
   input  wire                        clock,
   input  wire                        advance,
   input  wire  uvs_pkg::cordic_type  from_prev,
   output uvs_pkg::cordic_type        to_next
);
   import uvs_pkg::*;

   localparam logic signed [CORDIC_BITS-1:0] ANGLE = cordic_atan(ITER);

   cordic_type                    cor_ff;
   cordic_type                    cor_in;
   logic signed [CORDIC_BITS-1:0] dx;
   logic signed [CORDIC_BITS-1:0] dy;

   always_comb begin
      dx     = from_prev.y >>> ITER;
      dy     = from_prev.x >>> ITER;
      cor_in = from_prev;
      if (!from_prev.hold) begin
         if (!from_prev.z[CORDIC_BITS-1]) begin
            cor_in.x = from_prev.x - dx;
            cor_in.y = from_prev.y + dy;
            cor_in.z = from_prev.z - ANGLE;
         end else begin
            cor_in.x = from_prev.x + dx;
            cor_in.y = from_prev.y - dy;
            cor_in.z = from_prev.z + ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cor_ff <= cor_in;
      end
   end

   assign to_next = cor_ff;

endmodule

`default_nettype wire

FILE: verif/tb_uv_sphere_vertex_and_index_gen_core.sv
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_and_index_gen_core
// self-checking bench of the uv sphere grid point generator: a bit-exact
// predictor (long division, 28-step cordic, rounding and saturation) fills an
// in-order queue of expected results, and every accepted result is compared
// field by field. several count settings are run, the extremes among them,
// with random bursts on the request side and random stalls on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
   logic                point_valid;
   logic signed [15:0]  pos_x;
   logic signed [15:0]  pos_y;
   logic signed [15:0]  pos_z;
   logic [16:0]         tex_u;
   logic [16:0]         tex_v;
   logic                upper_tri;
   logic                lower_tri;
   logic [20:0]         top_index;
   logic [20:0]         bottom_index;
} sphere_point_type;

class sphere_scoreboard;
   logic [10:0]      stack_reg = 11'd18;
   logic [10:0]      sector_reg = 11'd36;
   sphere_point_type pending[$];
   int               errors = 0;

   static const longint atan_step[28] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166885, 83443,
      41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

   function automatic longint unsigned clamp(input logic [10:0] v, input int lo);
      if (v < lo) return lo;
      if (v > 1024) return 1024;
      return v;
   endfunction

   function automatic void rotate(input logic [31:0] phase, output longint c,
                                  output longint s);
      longint x, y, z, dx, dy;
      z = phase[29:0];
      if (z == 0) begin
         x = 64'sd1 <<< 30;
         y = 0;
      end else begin
         x = 652032874;
         y = 0;
         for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_step[i];
            end else begin
               x += dx; y -= dy; z += atan_step[i];
            end
         end
      end
      case (phase[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic signed [15:0] to_q15(input longint v, input int sh);
      longint r;
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function void note_request(input logic [10:0] ring, input logic [10:0] sector);
      longint unsigned  stacks, sectors, r, s, k1;
      longint           ct, st, cp, sp;
      logic [31:0]      ph_t, ph_p;
      sphere_point_type e;
      stacks  = clamp(stack_reg, 2);
      sectors = clamp(sector_reg, 3);
      r = ring;
      s = sector;
      e = '{default: '0};
      if (r <= stacks && s <= sectors) begin
         e.point_valid = 1'b1;
         ph_t = 32'(((r << 32) + stacks) / (2 * stacks));
         ph_p = 32'(((s << 32) + sectors / 2) / sectors);
         rotate(ph_t, ct, st);
         rotate(ph_p, cp, sp);
         e.pos_x = to_q15(st * cp, 45);
         e.pos_y = to_q15(st * sp, 45);
         e.pos_z = to_q15(ct, 15);
         e.tex_u = 17'(((s << 16) + sectors / 2) / sectors);
         e.tex_v = 17'(((r << 16) + stacks / 2) / stacks);
         if (r < stacks && s < sectors) begin
            e.upper_tri = (r > 0);
            e.lower_tri = (r != stacks - 1);
         end
         k1 = r * (sectors + 1) + s;
         e.top_index    = k1[20:0];
         e.bottom_index = 21'(k1 + sectors + 1);
      end
      pending = {pending, e};
   endfunction

   function void check_result(input sphere_point_type a);
      sphere_point_type e;
      if (pending.size() == 0) begin
         $error("result with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (a.point_valid !== e.point_valid) begin
         $error("point_valid exp %0d got %0d", e.point_valid, a.point_valid); errors++;
      end
      if (a.pos_x !== e.pos_x) begin
         $error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); errors++;
      end
      if (a.pos_y !== e.pos_y) begin
         $error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); errors++;
      end
      if (a.pos_z !== e.pos_z) begin
         $error("pos_z exp %0d got %0d", e.pos_z, a.pos_z); errors++;
      end
      if (a.tex_u !== e.tex_u) begin
         $error("tex_u exp %0d got %0d", e.tex_u, a.tex_u); errors++;
      end
      if (a.tex_v !== e.tex_v) begin
         $error("tex_v exp %0d got %0d", e.tex_v, a.tex_v); errors++;
      end
      if (a.upper_tri !== e.upper_tri) begin
         $error("upper_tri exp %0d got %0d", e.upper_tri, a.upper_tri); errors++;
      end
      if (a.lower_tri !== e.lower_tri) begin
         $error("lower_tri exp %0d got %0d", e.lower_tri, a.lower_tri); errors++;
      end
      if (a.top_index !== e.top_index) begin
         $error("top_index exp %0d got %0d", e.top_index, a.top_index); errors++;
      end
      if (a.bottom_index !== e.bottom_index) begin
         $error("bottom_index exp %0d got %0d", e.bottom_index, a.bottom_index);
         errors++;
      end
   endfunction
endclass

module tb_uv_sphere_vertex_and_index_gen_core;
   import uvs_pkg::*;

   // index that no register answers to
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [IDX_BITS-1:0]       req_ring = '0;
   logic [IDX_BITS-1:0]       req_sector = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_point_valid;
   logic signed [15:0]        rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [TEX_BITS-1:0]       rsp_tex_u, rsp_tex_v;
   logic                      rsp_upper_tri, rsp_lower_tri;
   logic [VTX_BITS-1:0]       rsp_top_index, rsp_bottom_index;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [IDX_BITS-1:0]       csr_data = '0;

   sphere_scoreboard sb = new();
   int burst_left = 0;
   int stall_run = 0;
   int stall_mode = 0;
   logic stall_level = 1'b0;

   uv_sphere_vertex_and_index_gen_core DUT (.*);

   always #6 clock = ~clock;

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   // result side stall pattern
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_run  = $urandom_range(1, 16);
         stall_mode = $urandom_range(0, 3);
         stall_level = (stall_mode == 1) ? ($urandom_range(0, 2) == 0) : ~stall_level;
      end
      stall_run--;
      rsp_stall <= (stall_mode == 0) ? 1'b0 : stall_level;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_point_valid, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u,
                           rsp_tex_v, rsp_upper_tri, rsp_lower_tri, rsp_top_index,
                           rsp_bottom_index});
   end

   task automatic send_point(input logic [10:0] ring, input logic [10:0] sector);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_ring   <= ring;
      req_sector <= sector;
      do @(posedge clock); while (req_stall);
      sb.note_request(ring, sector);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [10:0] data);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_STACK_COUNT) sb.stack_reg = data;
      else if (idx == CSR_SECTOR_COUNT) sb.sector_reg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sb.pending.size() > 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic random_points(input int n);
      int unsigned stacks, sectors;
      int          pick;
      stacks  = 32'(sb.clamp(sb.stack_reg, 2));
      sectors = 32'(sb.clamp(sb.sector_reg, 3));
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            send_point(11'($urandom_range(0, stacks)), 11'($urandom_range(0, sectors)));
         else if (pick == 7)
            send_point(11'($urandom_range(0, 4) == 0 ? stacks : 0),
                       11'($urandom_range(0, 2) == 0 ? sectors : $urandom_range(0, sectors)));
         else
            send_point(11'($urandom), 11'($urandom));
      end
   endtask

   initial begin
      int settings[6][2] = '{'{18, 36}, '{2, 3}, '{1024, 1024}, '{0, 0},
                             '{2047, 2047}, '{0, 0}};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // poles, seams, quarter turns and out of range under reset counts
      send_point(0, 0);      send_point(18, 0);     send_point(0, 36);
      send_point(18, 36);    send_point(17, 35);    send_point(9, 9);
      send_point(9, 18);     send_point(9, 27);     send_point(1, 1);
      send_point(19, 0);     send_point(0, 37);     send_point(2047, 2047);
      send_point(18, 37);    send_point(1024, 5);   send_point(3, 1024);
      drain();
      write_reg(CSR_UNUSED_INDEX, 11'h7FF);
      for (int p = 0; p < 6; p++) begin
         if (p == 5) begin
            settings[p][0] = int'($urandom_range(0, 2047));
            settings[p][1] = int'($urandom_range(0, 2047));
         end
         write_reg(CSR_STACK_COUNT, 11'(settings[p][0]));
         write_reg(CSR_SECTOR_COUNT, 11'(settings[p][1]));
         if (p == 2) begin
            send_point(1024, 1024);
            send_point(1023, 1023);
            send_point(512, 256);
         end
         random_points(135);
         drain();
      end
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
